// ===== design/hssg_pkg.sv =====
`timescale 1ns / 1ps

package hssg_pkg;

    localparam int LANES     = 4;
    localparam int AMP_W     = 15;
    localparam int SINE_W    = 15;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TUNING_WORD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_PARTIALS = 2'd2;

    localparam int DEF_SAMPLES_PER_RUN = 4096;
    localparam int DEF_TABLE_BITS      = 10;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int QUEUE_DEPTH         = 4;

    // frequency multiple of each partial
    localparam int unsigned HARM_MULT [LANES] = '{1, 10, 100, 1000};

    // full divisor of each term: weight divisor times full-scale sine
    localparam int DIVISOR_W = 20;
    localparam logic [DIVISOR_W-1:0] DIVISOR [LANES] =
        '{20'd327670, 20'd655340, 20'd32767, 20'd163835};

    // floor(2^RECIP_SHIFT / DIVISOR); quotient comes out at most one low
    localparam int RECIP_SHIFT = 46;
    localparam logic [31:0] RECIP [LANES] = '{
        32'((64'd1 << RECIP_SHIFT) / 64'd327670),
        32'((64'd1 << RECIP_SHIFT) / 64'd655340),
        32'((64'd1 << RECIP_SHIFT) / 64'd32767),
        32'((64'd1 << RECIP_SHIFT) / 64'd163835)
    };

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [AMP_W-1:0] amplitude;
        logic             four_partials;
    } synth_cfg_t;

    // First-quadrant sine magnitude, Q30 Taylor series, rounded to unsigned Q0.15.
    // Only evaluated at elaboration to fill the lookup table.
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [31:0] r, input int tb);
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] acc;
        a    = (64'(r) * HALF_PI_Q30) >> (tb - 2);
        a2   = (a * a) >> 30;
        term = a;
        acc  = $signed(a);
        term = ((term * a2) >> 30) / 64'd6;
        acc  = acc - $signed(term);
        term = ((term * a2) >> 30) / 64'd20;
        acc  = acc + $signed(term);
        term = ((term * a2) >> 30) / 64'd42;
        acc  = acc - $signed(term);
        term = ((term * a2) >> 30) / 64'd72;
        acc  = acc + $signed(term);
        term = ((term * a2) >> 30) / 64'd110;
        acc  = acc - $signed(term);
        if (acc < 0)
        begin
            acc = '0;
        end
        v = ((64'(acc) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ===== design/hssg_queue.sv =====
`timescale 1ns / 1ps

module hssg_queue #(
    parameter int WIDTH = 41,
    parameter int DEPTH = hssg_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    import hssg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("item pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("item popped from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== design/hssg_front.sv =====
`timescale 1ns / 1ps

module hssg_front #(
    parameter int SAMPLES_PER_RUN = hssg_pkg::DEF_SAMPLES_PER_RUN,
    parameter int TABLE_BITS      = hssg_pkg::DEF_TABLE_BITS,
    parameter int PHASE_BITS      = hssg_pkg::DEF_PHASE_BITS
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         tick_valid,
    output logic                                         tick_ready,
    input  logic                                         restart,
    input  logic [hssg_pkg::LANES-1:0][PHASE_BITS-1:0]   inc,
    output logic                                         q_push,
    output logic [hssg_pkg::LANES*TABLE_BITS:0]          q_data,
    input  logic                                         q_full
);
    import hssg_pkg::*;

    localparam int CNT_W = (SAMPLES_PER_RUN > 2) ? $clog2(SAMPLES_PER_RUN) : 1;

    logic [PHASE_BITS-1:0] phase_reg  [LANES];
    logic [PHASE_BITS-1:0] phase_next [LANES];
    logic [PHASE_BITS-1:0] base_phase [LANES];
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [CNT_W-1:0]      base_cnt;
    logic                  is_last;
    logic                  accept;

    assign tick_ready = !q_full;
    assign accept     = tick_valid && !q_full;
    assign q_push     = accept;

    always_comb
    begin
        base_cnt = restart ? '0 : cnt_reg;
        is_last  = (base_cnt == CNT_W'(SAMPLES_PER_RUN - 1));
        cnt_next = is_last ? '0 : base_cnt + 1'b1;
        for (int k = 0; k < LANES; k++)
        begin
            base_phase[k] = restart ? '0 : phase_reg[k];
            // run ends: every accumulator starts over from zero
            phase_next[k] = is_last ? '0 : base_phase[k] + inc[k];
            q_data[k*TABLE_BITS +: TABLE_BITS] = base_phase[k][PHASE_BITS-1 -: TABLE_BITS];
        end
        q_data[LANES*TABLE_BITS] = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int k = 0; k < LANES; k++)
            begin
                phase_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
            for (int k = 0; k < LANES; k++)
            begin
                phase_reg[k] <= phase_next[k];
            end
        end
    end

    a_run_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> cnt_reg == '0 && phase_reg[0] == '0)
        else $error("run did not restart after last sample");

endmodule

// ===== design/hssg_back.sv =====
`timescale 1ns / 1ps

module hssg_back #(
    parameter int TABLE_BITS = hssg_pkg::DEF_TABLE_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_valid,
    output logic                                     q_pop,
    input  logic [hssg_pkg::LANES*TABLE_BITS:0]      q_data,
    input  hssg_pkg::synth_cfg_t                     cfg,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic signed [hssg_pkg::SAMPLE_W-1:0]     sample,
    output logic                                     last,
    output logic                                     clipped
);
    import hssg_pkg::*;

    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int ADDR_W  = TABLE_BITS - 1;
    localparam int PROD_W  = AMP_W + SINE_W;
    localparam int WIDE_W  = PROD_W + 32;
    localparam int BACK_W  = SINE_W + DIVISOR_W;
    localparam int TERM_W  = SINE_W + 2;
    localparam int SUM_W   = TERM_W + 2;

    typedef logic [SINE_W-1:0] qtab_t [QUARTER+1];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i <= QUARTER; i++)
        begin
            t[i] = quarter_sine(32'(i), TABLE_BITS);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic adv;

    // stage A: table lookup
    logic [SINE_W-1:0]  mag_next   [LANES];
    logic               neg_next   [LANES];
    logic [SINE_W-1:0]  a_mag_reg  [LANES];
    logic               a_neg_reg  [LANES];
    logic               a_last_reg;
    logic               a_valid_reg;
    // stage B: amplitude times sine
    logic [PROD_W-1:0]  b_prod_reg [LANES];
    logic               b_neg_reg  [LANES];
    logic               b_last_reg;
    logic               b_valid_reg;
    // stage C: reciprocal multiply
    logic [WIDE_W-1:0]  recip_prod [LANES];
    logic [SINE_W-1:0]  c_quot_reg [LANES];
    logic [PROD_W-1:0]  c_prod_reg [LANES];
    logic               c_neg_reg  [LANES];
    logic               c_last_reg;
    logic               c_valid_reg;
    // stage D: quotient correction and sign
    logic [BACK_W-1:0]          back_prod [LANES];
    logic [BACK_W-1:0]          rem       [LANES];
    logic [SINE_W:0]            quot_fix  [LANES];
    logic signed [TERM_W-1:0]   term_next [LANES];
    logic signed [TERM_W-1:0]   d_term_reg [LANES];
    logic                       d_last_reg;
    logic                       d_valid_reg;
    // stage E: sum and saturate
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                       clipped_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic                       clipped_reg;
    logic                       out_valid_reg;

    assign adv          = !out_valid_reg || result_ready;
    assign q_pop        = adv && q_valid;
    assign result_valid = out_valid_reg;
    assign sample       = sample_reg;
    assign last         = last_reg;
    assign clipped      = clipped_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            logic [TABLE_BITS-1:0] idx;
            logic [1:0]            quad;
            logic [ADDR_W-1:0]     addr;
            idx  = q_data[k*TABLE_BITS +: TABLE_BITS];
            quad = idx[TABLE_BITS-1 -: 2];
            // odd quadrants run the table backwards
            addr = quad[0] ? ADDR_W'(QUARTER) - ADDR_W'(idx[TABLE_BITS-3:0])
                           : ADDR_W'(idx[TABLE_BITS-3:0]);
            mag_next[k] = QTAB[addr];
            neg_next[k] = quad[1];
        end
        // 1000x partial still advances but drops out of the sum
        if (!cfg.four_partials)
        begin
            mag_next[LANES-1] = '0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            recip_prod[k] = WIDE_W'(b_prod_reg[k]) * WIDE_W'(RECIP[k]);
            back_prod[k]  = BACK_W'(c_quot_reg[k]) * BACK_W'(DIVISOR[k]);
            rem[k]        = BACK_W'(c_prod_reg[k]) - back_prod[k];
            quot_fix[k]   = (SINE_W + 1)'(c_quot_reg[k])
                          + (SINE_W + 1)'(rem[k] >= BACK_W'(DIVISOR[k]));
            term_next[k]  = c_neg_reg[k] ? -$signed({1'b0, quot_fix[k]})
                                         :  $signed({1'b0, quot_fix[k]});
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < LANES; k++)
        begin
            sum = sum + SUM_W'(d_term_reg[k]);
        end
        priority if (sum > SUM_W'(32767))
        begin
            sample_next  = 16'sh7fff;
            clipped_next = 1'b1;
        end
        else if (sum < -SUM_W'(32768))
        begin
            sample_next  = 16'sh8000;
            clipped_next = 1'b1;
        end
        else
        begin
            sample_next  = sum[SAMPLE_W-1:0];
            clipped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= q_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                a_mag_reg[k]  <= mag_next[k];
                a_neg_reg[k]  <= neg_next[k];
                b_prod_reg[k] <= PROD_W'(cfg.amplitude) * PROD_W'(a_mag_reg[k]);
                b_neg_reg[k]  <= a_neg_reg[k];
                c_quot_reg[k] <= recip_prod[k][RECIP_SHIFT +: SINE_W];
                c_prod_reg[k] <= b_prod_reg[k];
                c_neg_reg[k]  <= b_neg_reg[k];
                d_term_reg[k] <= term_next[k];
            end
            a_last_reg  <= q_data[LANES*TABLE_BITS];
            b_last_reg  <= a_last_reg;
            c_last_reg  <= b_last_reg;
            d_last_reg  <= c_last_reg;
            last_reg    <= d_last_reg;
            sample_reg  <= sample_next;
            clipped_reg <= clipped_next;
        end
    end

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clipped_reg |-> sample_reg == 16'sh7fff || sample_reg == 16'sh8000)
        else $error("clipped sample not at a rail");
    a_pop_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> a_valid_reg)
        else $error("popped item lost in pipeline");

endmodule

// ===== design/harmonic_sine_sum_generator.sv =====
`timescale 1ns / 1ps

// Additive sine generator: each accepted tick item yields one 16-bit sample, the
// saturated sum of partials at 1x, 10x, 100x and (optionally) 1000x the base
// frequency, each from its own phase accumulator and a quarter-wave sine table.
// One item per clock is sustained while result_ready is high; a sample is presented
// once its tick has been accepted and has passed the table lookup at the front queue
// head, amplitude multiply, reciprocal multiply, quotient correction and
// sum/saturate stages. While a finished sample waits on result_ready the back
// pipeline holds and the 4-entry queue keeps taking ticks until it fills. The
// per-sample phase add in the front sets the one-item-per-cycle rate. Registers:
// index 0 amplitude, 1 tuning_word, 2 four_partials; write them only while no
// sample is in flight. last marks the final sample of each run, after which all
// phases restart from zero.
module harmonic_sine_sum_generator #(
    parameter int SAMPLES_PER_RUN = hssg_pkg::DEF_SAMPLES_PER_RUN,
    parameter int TABLE_BITS      = hssg_pkg::DEF_TABLE_BITS,
    parameter int PHASE_BITS      = hssg_pkg::DEF_PHASE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hssg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hssg_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 tick_valid,
    output logic                                 tick_ready,
    input  logic                                 restart,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [hssg_pkg::SAMPLE_W-1:0] sample,
    output logic                                 last,
    output logic                                 clipped
);
    import hssg_pkg::*;

    localparam int Q_WIDTH = LANES * TABLE_BITS + 1;
    localparam int INC_W   = ((PHASE_BITS > CFG_W) ? PHASE_BITS : CFG_W) + 10;

    logic [AMP_W-1:0]                 amplitude_reg;
    logic                             four_partials_reg;
    logic [LANES-1:0][PHASE_BITS-1:0] inc_reg;
    logic [LANES-1:0][PHASE_BITS-1:0] inc_next;
    logic [INC_W-1:0]                 inc_wide [LANES];
    synth_cfg_t                       cfg;

    logic               q_push;
    logic [Q_WIDTH-1:0] q_push_data;
    logic               q_full;
    logic               q_pop;
    logic [Q_WIDTH-1:0] q_pop_data;
    logic               q_not_empty;

    // phase increments are taken modulo the accumulator width
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            inc_wide[k] = INC_W'(cfg_data) * INC_W'(HARM_MULT[k]);
            inc_next[k] = inc_wide[k][PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg     <= '0;
            four_partials_reg <= 1'b0;
            inc_reg           <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AMPLITUDE:     amplitude_reg     <= cfg_data[AMP_W-1:0];
                REG_TUNING_WORD:   inc_reg           <= inc_next;
                REG_FOUR_PARTIALS: four_partials_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.amplitude     = amplitude_reg;
    assign cfg.four_partials = four_partials_reg;

    hssg_front #(
        .SAMPLES_PER_RUN (SAMPLES_PER_RUN),
        .TABLE_BITS      (TABLE_BITS),
        .PHASE_BITS      (PHASE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .restart    (restart),
        .inc        (inc_reg),
        .q_push     (q_push),
        .q_data     (q_push_data),
        .q_full     (q_full)
    );

    hssg_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    hssg_back #(
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_pop        (q_pop),
        .q_data       (q_pop_data),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sample       (sample),
        .last         (last),
        .clipped      (clipped)
    );

endmodule
